@@ hw/rtl/ogs_pkg.sv @@
`default_nettype none

package ogs_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_CIRCLE = 2'd1,
    OP_RECT   = 2'd2,
    OP_READ   = 2'd3
  } ogs_op_e;

  typedef struct packed {
    ogs_op_e    opcode;
    logic [5:0] center_x;
    logic [5:0] center_y;
    logic [4:0] radius;
    logic [5:0] rect_width;
    logic [5:0] rect_height;
    logic [4:0] margin;
    logic       fill_value;
  } ogs_cmd_t;

  typedef struct packed {
    logic cell_value;
    logic in_grid;
  } ogs_rsp_t;

  localparam logic CELL_EMPTY = 1'b1;

endpackage

`default_nettype wire

@@ hw/rtl/ogs_stream_if.sv @@
`default_nettype none

interface ogs_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

@@ hw/rtl/occupancy_grid_shape_stamper.sv @@
// Channel | Dir | Payload    | Word accepted when
// --------+-----+------------+--------------------------------
// cmd_i   | in  | ogs_cmd_t  | cmd_i.valid && cmd_i.ready
// rsp_o   | out | ogs_rsp_t  | rsp_o.valid && rsp_o.ready
//
// A circle scans (2r+1)^2 cells and a rectangle 4*(2m+1)^2 + (2ow+1)*(2oh+1) cells,
// with ow and oh the widened half extents: the grid memory has one write port, one cell a cycle.
// A clear sweeps all GRID_WIDTH*GRID_HEIGHT cells, one a cycle.
// After reset the same sweep runs before cmd_i is ready.
// One command is in work at a time; a finished word waits in the output register and
// the next command is taken while it waits. The block stalls only if that register is full.
`default_nettype none

module occupancy_grid_shape_stamper #(
  parameter int GRID_WIDTH  = 61,
  parameter int GRID_HEIGHT = 41
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ogs_stream_if.sink   cmd_i,
  ogs_stream_if.source rsp_o
);

  import ogs_pkg::*;

  localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(GRID_WIDTH);
  localparam int YW    = $clog2(GRID_HEIGHT);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SWEEP = 6'b000010,
    ST_STAMP = 6'b000100,
    ST_DRAIN = 6'b001000,
    ST_READ  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [AW-1:0]     sweep_q, sweep_d;
  logic              rsp_due_q, rsp_due_d;
  logic [2:0]        phase_q, phase_d;
  logic signed [6:0] dx_q, dx_d, dy_q, dy_d;
  logic              st_we_q, st_we_d;
  logic [XW-1:0]     gx_q;
  logic [YW-1:0]     gy_q;
  logic              rsp_valid_q, rsp_valid_d;
  ogs_rsp_t          rsp_q, rsp_d;

  ogs_op_e           op_q;
  logic [5:0]        cx_q, cy_q;
  logic [4:0]        hw_q, hh_q, rad_q;
  logic              fill_q, rd_in_q;

  logic              grid_mem [DEPTH];
  logic              rdata_q;

  logic              cmd_acc;
  logic [4:0]        rad_in;
  logic              rd_in;

  logic              box_ph, centre_ph, nxt_box;
  logic [5:0]        ow, oh, ext_x, ext_y, nxt_x, nxt_y;
  logic signed [6:0] ext_x_s, ext_y_s;
  logic [7:0]        ccx_u, ccy_u;
  logic signed [9:0] gx, gy;
  logic              gx_in, gy_in;
  logic [5:0]        adx, ady;
  logic [11:0]       sqx, sqy;
  logic [9:0]        rr;
  logic [12:0]       sq_sum;
  logic              hit_disk, hit_box, hit;
  logic              last_dx, last_dy;

  logic              mem_we, mem_wdata, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;

  assign cmd_i.ready = (state_q == ST_IDLE);
  assign cmd_acc     = cmd_i.valid && cmd_i.ready;
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  assign rad_in = (cmd_i.data.opcode == OP_CIRCLE) ? cmd_i.data.radius : cmd_i.data.margin;
  assign rd_in  = (cmd_i.data.opcode == OP_READ)
               && ({3'b000, cmd_i.data.center_x} < 9'(GRID_WIDTH))
               && ({3'b000, cmd_i.data.center_y} < 9'(GRID_HEIGHT));

  // Phases 0 to 3 of a rectangle are the corner disks, phase 4 is the widened box.
  assign box_ph    = (op_q == OP_RECT) && (phase_q == 3'd4);
  assign centre_ph = (op_q != OP_RECT) || box_ph;
  assign nxt_box   = (phase_q == 3'd3);
  assign ow        = {1'b0, hw_q} + {1'b0, rad_q};
  assign oh        = {1'b0, hh_q} + {1'b0, rad_q};
  assign ext_x     = box_ph ? ow : {1'b0, rad_q};
  assign ext_y     = box_ph ? oh : {1'b0, rad_q};
  assign nxt_x     = nxt_box ? ow : {1'b0, rad_q};
  assign nxt_y     = nxt_box ? oh : {1'b0, rad_q};
  assign ext_x_s   = {1'b0, ext_x};
  assign ext_y_s   = {1'b0, ext_y};

  always_comb begin
    ccx_u = {2'b00, cx_q};
    ccy_u = {2'b00, cy_q};
    if (!centre_ph) begin
      ccx_u = phase_q[1] ? ({2'b00, cx_q} + {3'b000, hw_q}) : ({2'b00, cx_q} - {3'b000, hw_q});
      ccy_u = phase_q[0] ? ({2'b00, cy_q} + {3'b000, hh_q}) : ({2'b00, cy_q} - {3'b000, hh_q});
    end
  end

  assign gx    = {{2{ccx_u[7]}}, ccx_u} + {{3{dx_q[6]}}, dx_q};
  assign gy    = {{2{ccy_u[7]}}, ccy_u} + {{3{dy_q[6]}}, dy_q};
  assign gx_in = (gx[9] == 1'b0) && ($unsigned(gx) < 10'(GRID_WIDTH));
  assign gy_in = (gy[9] == 1'b0) && ($unsigned(gy) < 10'(GRID_HEIGHT));

  assign adx      = dx_q[6] ? 6'(-dx_q) : dx_q[5:0];
  assign ady      = dy_q[6] ? 6'(-dy_q) : dy_q[5:0];
  assign sqx      = {6'd0, adx} * {6'd0, adx};
  assign sqy      = {6'd0, ady} * {6'd0, ady};
  assign rr       = {5'd0, rad_q} * {5'd0, rad_q};
  assign sq_sum   = {1'b0, sqx} + {1'b0, sqy};
  assign hit_disk = (sq_sum <= {3'b000, rr});
  assign hit_box  = !((adx > {1'b0, hw_q}) && (ady > {1'b0, hh_q}));
  assign hit      = box_ph ? hit_box : hit_disk;

  assign last_dx = (dx_q == ext_x_s);
  assign last_dy = (dy_q == ext_y_s);

  always_comb begin
    state_d     = state_q;
    sweep_d     = sweep_q;
    rsp_due_d   = rsp_due_q;
    phase_d     = phase_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    st_we_d     = 1'b0;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_d       = rsp_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_acc) begin
          unique case (cmd_i.data.opcode)
            OP_CLEAR: begin
              state_d   = ST_SWEEP;
              sweep_d   = '0;
              rsp_due_d = 1'b1;
            end
            OP_CIRCLE, OP_RECT: begin
              state_d = ST_STAMP;
              phase_d = 3'd0;
              dx_d    = 7'd0 - {2'b00, rad_in};
              dy_d    = 7'd0 - {2'b00, rad_in};
            end
            OP_READ: state_d = ST_READ;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SWEEP: begin
        sweep_d = sweep_q + 1'b1;
        if (sweep_q == AW'(DEPTH - 1)) begin
          state_d = rsp_due_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_STAMP: begin
        st_we_d = hit && gx_in && gy_in;
        if (!last_dy) begin
          dy_d = dy_q + 7'sd1;
        end else begin
          dy_d = -ext_y_s;
          if (!last_dx) begin
            dx_d = dx_q + 7'sd1;
          end else if ((op_q != OP_RECT) || box_ph) begin
            state_d = ST_DRAIN;
          end else begin
            phase_d = phase_q + 3'd1;
            dx_d    = 7'd0 - {1'b0, nxt_x};
            dy_d    = 7'd0 - {1'b0, nxt_y};
          end
        end
      end
      ST_DRAIN: state_d = ST_DONE;
      ST_READ:  state_d = ST_DONE;
      ST_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d      = 1'b1;
          rsp_d.cell_value = rd_in_q & rdata_q;
          rsp_d.in_grid    = rd_in_q;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      sweep_q     <= '0;
      rsp_due_q   <= 1'b0;
      phase_q     <= 3'd0;
      dx_q        <= '0;
      dy_q        <= '0;
      st_we_q     <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      rsp_due_q   <= rsp_due_d;
      phase_q     <= phase_d;
      dx_q        <= dx_d;
      dy_q        <= dy_d;
      st_we_q     <= st_we_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    gx_q  <= gx[XW-1:0];
    gy_q  <= gy[YW-1:0];
    if (cmd_acc) begin
      op_q    <= cmd_i.data.opcode;
      cx_q    <= cmd_i.data.center_x;
      cy_q    <= cmd_i.data.center_y;
      hw_q    <= cmd_i.data.rect_width[5:1];
      hh_q    <= cmd_i.data.rect_height[5:1];
      rad_q   <= rad_in;
      fill_q  <= cmd_i.data.fill_value;
      rd_in_q <= rd_in;
    end
  end

  // The stamp write is registered, landing in the cycle after the cell is chosen; the drain
  // state lets the last one settle before the result goes out, so a following read sees it.
  assign mem_we    = (state_q == ST_SWEEP) || st_we_q;
  assign mem_wdata = (state_q == ST_SWEEP) ? CELL_EMPTY : fill_q;
  assign mem_waddr = (state_q == ST_SWEEP) ? sweep_q
                   : AW'(AW'(gy_q) * AW'(GRID_WIDTH) + AW'(gx_q));
  assign mem_re    = (state_q == ST_READ) && rd_in_q;
  assign mem_raddr = AW'(AW'(cy_q) * AW'(GRID_WIDTH) + AW'(cx_q));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      grid_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= grid_mem[mem_raddr];
    end
  end

  a_stamp_write_in_stamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_we_q |-> (state_q == ST_STAMP) || (state_q == ST_DRAIN))
    else $error("stamp write pending outside the stamp sequence");

  a_offset_y_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STAMP) |-> (dy_q <= ext_y_s) && (dy_q >= -ext_y_s))
    else $error("row offset left the shape extent");

  a_offset_x_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STAMP) |-> (dx_q <= ext_x_s) && (dx_q >= -ext_x_s))
    else $error("column offset left the shape extent");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STAMP) |-> (phase_q <= 3'd4) && ((op_q == OP_RECT) || (phase_q == 3'd0)))
    else $error("stamp phase out of range");

  a_cell_only_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !rsp_q.in_grid) |-> !rsp_q.cell_value)
    else $error("cell value reported without an in-grid read");

endmodule

`default_nettype wire

@@ bench/occupancy_grid_shape_stamper_checker.sv @@
`timescale 1ns / 1ps

module occupancy_grid_shape_stamper_checker #(
  parameter int GRID_WIDTH  = 61,
  parameter int GRID_HEIGHT = 41
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  logic              cmd_ready_i,
  input  ogs_pkg::ogs_cmd_t cmd_i,
  input  logic              rsp_valid_i,
  input  logic              rsp_ready_i,
  input  ogs_pkg::ogs_rsp_t rsp_i,
  output int                fail_count_o,
  output int                pending_o
);

  import ogs_pkg::*;

  localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;

  bit       occupancy [CELLS];
  ogs_rsp_t expected_read_q [$];
  int       fail_count;

  function automatic void wipe_grid();
    for (int i = 0; i < CELLS; i++) begin
      occupancy[i] = CELL_EMPTY;
    end
  endfunction

  function automatic void put_cell(int gx, int gy, bit v);
    if (gx < 0 || gx >= GRID_WIDTH || gy < 0 || gy >= GRID_HEIGHT) return;
    occupancy[gy * GRID_WIDTH + gx] = v;
  endfunction

  function automatic void paint_disk(int cx, int cy, int r, bit v);
    for (int dx = -r; dx <= r; dx++) begin
      for (int dy = -r; dy <= r; dy++) begin
        if (dx * dx + dy * dy <= r * r) put_cell(cx + dx, cy + dy, v);
      end
    end
  endfunction

  function automatic void paint_rounded_box(int cx, int cy, int w, int h, int m, bit v);
    int hw, hh, ow, oh;
    bit out_x, out_y;
    hw = w / 2;
    hh = h / 2;
    ow = (w + 2 * m) / 2;
    oh = (h + 2 * m) / 2;
    paint_disk(cx - hw, cy - hh, m, v);
    paint_disk(cx - hw, cy + hh, m, v);
    paint_disk(cx + hw, cy - hh, m, v);
    paint_disk(cx + hw, cy + hh, m, v);
    // The widened box leaves its corner squares to the disks.
    for (int dx = -ow; dx <= ow; dx++) begin
      for (int dy = -oh; dy <= oh; dy++) begin
        out_x = (dx < -hw || dx > hw);
        out_y = (dy < -hh || dy > hh);
        if (!(out_x && out_y)) put_cell(cx + dx, cy + dy, v);
      end
    end
  endfunction

  function automatic ogs_rsp_t apply_command(ogs_cmd_t c);
    ogs_rsp_t res;
    int cx, cy;
    res = '0;
    cx = int'(c.center_x);
    cy = int'(c.center_y);
    case (c.opcode)
      OP_CLEAR: begin
        wipe_grid();
      end
      OP_CIRCLE: begin
        paint_disk(cx, cy, int'(c.radius), c.fill_value);
      end
      OP_RECT: begin
        paint_rounded_box(cx, cy, int'(c.rect_width), int'(c.rect_height),
                          int'(c.margin), c.fill_value);
      end
      default: begin
        if (cx < GRID_WIDTH && cy < GRID_HEIGHT) begin
          res.in_grid    = 1'b1;
          res.cell_value = occupancy[cy * GRID_WIDTH + cx];
        end
      end
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    ogs_rsp_t want;
    if (!rst_ni) begin
      wipe_grid();
      expected_read_q.delete();
      fail_count = 0;
    end else begin
      // Results are taken before the new command so an empty queue is caught.
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_read_q.size() == 0) begin
          $display("%0t: result word with none expected, actual cell_value %b in_grid %b",
                   $time, rsp_i.cell_value, rsp_i.in_grid);
          fail_count++;
        end else begin
          want = expected_read_q.pop_front();
          if (rsp_i.cell_value !== want.cell_value) begin
            $display("%0t: cell_value expected %b actual %b",
                     $time, want.cell_value, rsp_i.cell_value);
            fail_count++;
          end
          if (rsp_i.in_grid !== want.in_grid) begin
            $display("%0t: in_grid expected %b actual %b",
                     $time, want.in_grid, rsp_i.in_grid);
            fail_count++;
          end
        end
      end
      if (cmd_valid_i && cmd_ready_i) expected_read_q.push_back(apply_command(cmd_i));
    end
    fail_count_o <= fail_count;
    pending_o    <= expected_read_q.size();
  end

endmodule

@@ bench/occupancy_grid_shape_stamper_tb.sv @@
`timescale 1ns / 1ps

module occupancy_grid_shape_stamper_tb;
  import ogs_pkg::*;

  localparam int GRID_WIDTH   = 61;
  localparam int GRID_HEIGHT  = 41;
  localparam int RANDOM_WORDS = 115;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int cmd_gap_max   = 5;
  int rsp_stall_max = 5;
  int rsp_hold_req  = 0;
  int fail_count;
  int pending_words;

  ogs_stream_if #(.payload_t(ogs_cmd_t)) cmd_if ();
  ogs_stream_if #(.payload_t(ogs_rsp_t)) rsp_if ();

  always #5 clk_i = ~clk_i;

  occupancy_grid_shape_stamper #(
    .GRID_WIDTH (GRID_WIDTH),
    .GRID_HEIGHT(GRID_HEIGHT)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .rsp_o (rsp_if)
  );

  occupancy_grid_shape_stamper_checker #(
    .GRID_WIDTH (GRID_WIDTH),
    .GRID_HEIGHT(GRID_HEIGHT)
  ) grid_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_if.valid),
    .cmd_ready_i (cmd_if.ready),
    .cmd_i       (cmd_if.data),
    .rsp_valid_i (rsp_if.valid),
    .rsp_ready_i (rsp_if.ready),
    .rsp_i       (rsp_if.data),
    .fail_count_o(fail_count),
    .pending_o   (pending_words)
  );

  function automatic ogs_cmd_t make_cmd(ogs_op_e op, int x, int y, int r, int w, int h,
                                        int m, bit v);
    ogs_cmd_t c;
    c.opcode      = op;
    c.center_x    = 6'(x);
    c.center_y    = 6'(y);
    c.radius      = 5'(r);
    c.rect_width  = 6'(w);
    c.rect_height = 6'(h);
    c.margin      = 5'(m);
    c.fill_value  = v;
    return c;
  endfunction

  // Shape fields of a read are don't-care, so they are randomized.
  function automatic ogs_cmd_t read_at(int x, int y);
    return make_cmd(OP_READ, x, y, $urandom_range(0, 31), $urandom_range(0, 63),
                    $urandom_range(0, 63), $urandom_range(0, 31), 1'($urandom_range(0, 1)));
  endfunction

  task automatic issue(ogs_cmd_t c);
    int gap;
    gap = $urandom_range(0, cmd_gap_max);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= c;
    do @(posedge clk_i); while (!cmd_if.ready);
  endtask

  // The extra edge lets the checker count the word accepted last.
  task automatic wait_idle();
    cmd_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
  endtask

  initial begin : receiver
    int stall;
    rsp_if.ready = 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (rsp_hold_req > 0) begin
        stall        = rsp_hold_req;
        rsp_hold_req = 0;
      end else begin
        stall = $urandom_range(0, rsp_stall_max);
      end
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
    end
  end

  initial begin : stimulus
    int sent, next_chunk, kind, cx, cy, r, w, h, m, spread, reads, dx, dy;
    bit v, big, held;
    ogs_cmd_t c;
    logic [63:0] raw;

    cmd_if.valid = 1'b0;
    cmd_if.data  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reads of the fresh grid, on and off its edges.
    issue(read_at(0, 0));
    issue(read_at(GRID_WIDTH - 1, GRID_HEIGHT - 1));
    issue(read_at(GRID_WIDTH, GRID_HEIGHT - 1));
    issue(read_at(0, GRID_HEIGHT));
    issue(read_at(63, 63));
    // A zero radius marks only the centre cell.
    issue(make_cmd(OP_CIRCLE, 30, 20, 0, 0, 0, 0, 1'b0));
    issue(read_at(30, 20));
    issue(read_at(31, 20));
    // A circle clipped by the grid corner.
    issue(make_cmd(OP_CIRCLE, 0, 0, 3, 0, 0, 0, 1'b0));
    issue(read_at(2, 2));
    issue(read_at(3, 3));
    // Rounded box: probe a skipped corner square, a disk cell and the widened side.
    issue(make_cmd(OP_RECT, 30, 20, 0, 10, 6, 2, 1'b0));
    issue(read_at(37, 25));
    issue(read_at(36, 24));
    issue(read_at(37, 20));
    // Largest circle with its centre off the grid.
    issue(make_cmd(OP_CIRCLE, 63, 63, 31, 0, 0, 0, 1'b0));
    issue(read_at(GRID_WIDTH - 1, GRID_HEIGHT - 1));
    issue(make_cmd(OP_RECT, 10, 10, 0, 0, 0, 0, 1'b0));
    issue(read_at(10, 10));
    // Every shape field at its maximum.
    issue(make_cmd(OP_RECT, 63, 63, 31, 63, 63, 31, 1'b1));
    issue(read_at(30, 20));
    issue(make_cmd(OP_CLEAR, 63, 63, 31, 63, 63, 31, 1'b0));
    issue(read_at(2, 2));
    issue(make_cmd(OP_CIRCLE, 20, 20, 5, 0, 0, 0, 1'b1));
    issue(read_at(20, 20));

    sent       = 0;
    next_chunk = 0;
    held       = 1'b0;
    while (sent < RANDOM_WORDS) begin
      if (sent >= next_chunk) begin
        if (next_chunk == 0) begin
          cmd_gap_max   = 0;
          rsp_stall_max = 0;
        end else begin
          cmd_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 5;
          rsp_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
        end
        next_chunk += 20;
      end

      if (!held && sent >= RANDOM_WORDS / 2) begin
        // Hold the result side while words keep coming so the block backs up.
        held = 1'b1;
        wait_idle();
        rsp_hold_req = 400;
        cmd_gap_max  = 0;
        repeat (8) begin
          issue(read_at($urandom_range(0, 63), $urandom_range(0, 63)));
          sent++;
        end
        wait_idle();
        cmd_gap_max = 5;
      end

      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        issue(make_cmd(OP_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
                       $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63),
                       $urandom_range(0, 31), 1'($urandom_range(0, 1))));
        sent++;
      end else if (kind <= 2) begin
        raw      = {$urandom, $urandom};
        c        = raw[$bits(ogs_cmd_t)-1:0];
        c.margin = c.margin & 5'd7;
        issue(c);
        sent++;
      end else begin
        big = ($urandom_range(0, 11) == 0);
        cx  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                          : $urandom_range(0, GRID_WIDTH - 1);
        cy  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                          : $urandom_range(0, GRID_HEIGHT - 1);
        v   = ($urandom_range(0, 9) >= 7);
        if ($urandom_range(0, 1)) begin
          r      = big ? $urandom_range(0, 31) : $urandom_range(0, 7);
          spread = r + 1;
          issue(make_cmd(OP_CIRCLE, cx, cy, r, $urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom_range(0, 31), v));
        end else begin
          w      = big ? $urandom_range(0, 63) : $urandom_range(0, 20);
          h      = big ? $urandom_range(0, 63) : $urandom_range(0, 20);
          m      = big ? $urandom_range(0, 8) : $urandom_range(0, 4);
          spread = ((w > h ? w : h) + 2 * m) / 2 + 1;
          issue(make_cmd(OP_RECT, cx, cy, $urandom_range(0, 31), w, h, m, v));
        end
        sent++;
        // Reads around the shape, edge included, show what was stamped.
        reads = $urandom_range(1, 4);
        repeat (reads) begin
          dx = int'($urandom_range(0, 2 * spread)) - spread;
          dy = int'($urandom_range(0, 2 * spread)) - spread;
          issue(read_at(cx + dx, cy + dy));
          sent++;
        end
      end
    end

    wait_idle();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("occupancy_grid_shape_stamper: match");
    end else begin
      $display("occupancy_grid_shape_stamper: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #40_000_000;
    $display("occupancy_grid_shape_stamper: mismatch");
    $finish;
  end

endmodule
